[src/skor_pkg.sv]
// ----------------------------------------------------------------------------
// skor_pkg: shared types and constants for the sorted key occurrence range block
// Item layouts, internal command format and the widths that follow from the
// array capacity.
// ----------------------------------------------------------------------------
package skor_pkg;

   // Array capacity and derived widths
   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = ADDR_W + 1;      // holds 0..CAPACITY
   localparam int PTR_W    = CNT_W + 1;       // signed search bound, down to -1
   localparam int KEY_W    = 32;

   // Fixed result field widths
   localparam int IDX_OUT_W = 10;
   localparam int OCC_OUT_W = 11;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // Operation codes of an input item
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [1:0] {
      CMD_APPEND,
      CMD_RESTART,
      CMD_QUERY
   } cmd_kind_type;

   typedef struct packed {
      logic                    op;
      logic signed [KEY_W-1:0] value;
      logic                    start_req;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [IDX_OUT_W-1:0] first_index;
      logic [IDX_OUT_W-1:0] last_index;
      logic [OCC_OUT_W-1:0] occurrences;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic signed [KEY_W-1:0] value;
   } cmd_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

endpackage

[src/skor_front.sv]
// ----------------------------------------------------------------------------
// skor_front: input side of the occurrence range block
// Accepts items, classifies them into append, restart or query commands and
// holds them in a small queue until the back end takes them.
// ----------------------------------------------------------------------------
module skor_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  skor_pkg::req_type       req_item,
   output skor_pkg::queue_head_type head,
   input  logic                    pop
);

   skor_pkg::cmd_type                 entry_ff [skor_pkg::QUEUE_DEPTH];
   logic [skor_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [skor_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [skor_pkg::QCNT_W-1:0]       fill_ff, fill_in;
   logic                              push;
   logic                              do_pop;
   skor_pkg::cmd_type                 cmd;

   // Classify the incoming item
   always_comb begin
      cmd.value = req_item.value;
      if (req_item.op == skor_pkg::OP_QUERY) begin
         cmd.kind = skor_pkg::CMD_QUERY;
      end else if (req_item.start_req) begin
         cmd.kind = skor_pkg::CMD_RESTART;
      end else begin
         cmd.kind = skor_pkg::CMD_APPEND;
      end
   end

   // Queue handshake
   assign req_stall  = (fill_ff == skor_pkg::QCNT_W'(skor_pkg::QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign do_pop     = pop && (fill_ff != '0);
   assign head.valid = (fill_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

[src/skor_back.sv]
// ----------------------------------------------------------------------------
// skor_back: execution side of the occurrence range block
// Owns the element memory and count, performs appends and restarts, and runs the two
// binary searches (first and last occurrence) one read per cycle.
// ----------------------------------------------------------------------------
module skor_back (
   input  logic                     clock,
   input  logic                     reset,
   input  skor_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output skor_pkg::rsp_type        rsp_item
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESULT
   } state_type;

   // Element memory
   logic signed [skor_pkg::KEY_W-1:0] mem [skor_pkg::CAPACITY];
   logic signed [skor_pkg::KEY_W-1:0] rd_data_ff;
   logic [skor_pkg::ADDR_W-1:0]       rd_addr;
   logic                              wr_en;
   logic [skor_pkg::ADDR_W-1:0]       wr_addr;

   // Control and search state
   state_type                         state_ff, state_in;
   logic [skor_pkg::CNT_W-1:0]        count_ff, count_in;
   logic                              pass_last_ff, pass_last_in;
   logic signed [skor_pkg::KEY_W-1:0] key_ff, key_in;
   logic signed [skor_pkg::PTR_W-1:0] lo_ff, lo_in;
   logic signed [skor_pkg::PTR_W-1:0] hi_ff, hi_in;
   logic [skor_pkg::ADDR_W-1:0]       mid_ff, mid_in;
   logic [skor_pkg::ADDR_W-1:0]       hit_ff, hit_in;
   logic                              hit_v_ff, hit_v_in;
   logic [skor_pkg::ADDR_W-1:0]       first_ff, first_in;
   logic                              first_v_ff, first_v_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   skor_pkg::rsp_type                 rsp_ff, rsp_in;

   // Step datapath
   logic [skor_pkg::CNT_W-1:0]        load_base;
   logic [skor_pkg::CNT_W-1:0]        count_m1;
   logic [skor_pkg::ADDR_W-1:0]       mid0;
   logic signed [skor_pkg::PTR_W-1:0] hi0;
   logic signed [skor_pkg::PTR_W-1:0] mid_s;
   logic signed [skor_pkg::PTR_W-1:0] lo_n, hi_n;
   logic signed [skor_pkg::PTR_W:0]   sum_n;
   logic [skor_pkg::ADDR_W-1:0]       hit_n;
   logic                              hit_v_n;
   logic                              step_go;
   logic                              is_eq, is_gt;
   logic                              slot_free;
   logic                              found;
   logic [skor_pkg::CNT_W-1:0]        span;

   // Initial bounds of a pass
   assign count_m1 = count_ff - 1'b1;
   assign mid0     = count_m1[skor_pkg::ADDR_W:1];
   assign hi0      = $signed(skor_pkg::PTR_W'(count_ff)) - 2'sd1;

   // One search step on the word read last cycle
   assign mid_s = $signed(skor_pkg::PTR_W'(mid_ff));
   assign is_eq = (rd_data_ff == key_ff);
   assign is_gt = (rd_data_ff > key_ff);

   always_comb begin
      lo_n    = lo_ff;
      hi_n    = hi_ff;
      hit_n   = hit_ff;
      hit_v_n = hit_v_ff;
      if (is_eq) begin
         hit_n   = mid_ff;
         hit_v_n = 1'b1;
         if (pass_last_ff) begin
            lo_n = mid_s + 2'sd1;
         end else begin
            hi_n = mid_s - 2'sd1;
         end
      end else if (is_gt) begin
         hi_n = mid_s - 2'sd1;
      end else begin
         lo_n = mid_s + 2'sd1;
      end
   end

   assign sum_n   = (skor_pkg::PTR_W + 1)'(lo_n) + (skor_pkg::PTR_W + 1)'(hi_n);
   assign step_go = (lo_n <= hi_n);

   // Result formatting from both bounds
   assign found = first_v_ff && hit_v_ff && (hit_ff >= first_ff);
   assign span  = skor_pkg::CNT_W'(hit_ff) - skor_pkg::CNT_W'(first_ff) + 1'b1;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign load_base = (head.cmd.kind == skor_pkg::CMD_RESTART) ? '0 : count_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pass_last_in = pass_last_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      hit_in       = hit_ff;
      hit_v_in     = hit_v_ff;
      first_in     = first_ff;
      first_v_in   = first_v_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_addr      = mid_ff;
      wr_en        = 1'b0;
      wr_addr      = load_base[skor_pkg::ADDR_W-1:0];
      pop          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.cmd.kind == skor_pkg::CMD_QUERY) begin
                  key_in       = head.cmd.value;
                  pass_last_in = 1'b0;
                  lo_in        = '0;
                  hi_in        = hi0;
                  hit_v_in     = 1'b0;
                  first_v_in   = 1'b0;
                  rd_addr      = mid0;
                  mid_in       = mid0;
                  // Empty array: nothing to search
                  state_in     = (count_ff == '0) ? ST_RESULT : ST_SEARCH;
               end else if (load_base < skor_pkg::CNT_W'(skor_pkg::CAPACITY)) begin
                  wr_en    = 1'b1;
                  count_in = load_base + 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            if (step_go) begin
               lo_in    = lo_n;
               hi_in    = hi_n;
               hit_in   = hit_n;
               hit_v_in = hit_v_n;
               rd_addr  = sum_n[skor_pkg::ADDR_W:1];
               mid_in   = sum_n[skor_pkg::ADDR_W:1];
            end else if (!pass_last_ff) begin
               // First bound done, restart for the last bound
               first_in     = hit_n;
               first_v_in   = hit_v_n;
               pass_last_in = 1'b1;
               lo_in        = '0;
               hi_in        = hi0;
               hit_v_in     = 1'b0;
               rd_addr      = mid0;
               mid_in       = mid0;
            end else begin
               hit_in   = hit_n;
               hit_v_in = hit_v_n;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (found) begin
                  rsp_in.found       = 1'b1;
                  rsp_in.first_index = skor_pkg::IDX_OUT_W'(first_ff);
                  rsp_in.last_index  = skor_pkg::IDX_OUT_W'(hit_ff);
                  rsp_in.occurrences = skor_pkg::OCC_OUT_W'(span);
               end else begin
                  rsp_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pass_last_ff <= pass_last_in;
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      hit_ff       <= hit_in;
      hit_v_ff     <= hit_v_in;
      first_ff     <= first_in;
      first_v_ff   <= first_v_in;
      rsp_ff       <= rsp_in;
   end

   // Memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= head.cmd.value;
      end
   end

   // Memory read port, registered data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[src/sorted_key_occurrence_range_top.sv]
// Operation: a load item is written while the back end is idle; a query runs the
//   first-occurrence and then the last-occurrence binary search, one memory read
//   per step, and then formats the result.
// Throughput: the back end works on one item at a time; a 4-entry command queue
//   keeps accepting items while a search runs, until the queue is full.
// Reset: synchronous, clears the element count, the queue and the result valid.
// ----------------------------------------------------------------------------
// sorted_key_occurrence_range_top: first/last occurrence search over a loaded array
// Loads signed 32-bit elements one per item and answers key queries with
// found flag, first and last index and occurrence count.
// ----------------------------------------------------------------------------
module sorted_key_occurrence_range_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  skor_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output skor_pkg::rsp_type rsp_item
);

   skor_pkg::queue_head_type head;
   logic                     pop;

   // Accept and classify
   skor_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .head      (head),
      .pop       (pop)
   );

   // Execute loads and searches
   skor_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

[src/skor_checker.sv]
// ----------------------------------------------------------------------------
// skor_checker: port-level checks for the occurrence range block
// Watches both channels for handshake and result consistency.
// ----------------------------------------------------------------------------
module skor_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input skor_pkg::req_type req_item,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input skor_pkg::rsp_type rsp_item
);

   // A stalled input item stays put
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_item))
      else $error("input item changed while stalled");

   // A stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result changed while stalled");

   // No result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A miss carries all-zero indices and count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.found |->
         rsp_item.first_index == '0 && rsp_item.last_index == '0 &&
         rsp_item.occurrences == '0)
      else $error("miss with nonzero fields");

   // A hit has an ordered range whose count matches it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.found |->
         rsp_item.last_index >= rsp_item.first_index &&
         rsp_item.occurrences ==
            skor_pkg::OCC_OUT_W'(rsp_item.last_index - rsp_item.first_index) + 1'b1)
      else $error("hit with inconsistent range");

endmodule

bind sorted_key_occurrence_range_top skor_checker u_skor_checker (.*);
